@@ design/grouped_bitmap_block_allocator_unit_macros.svh @@
// Assertion macros shared by the allocator modules.
// Depends on a clk and rst signal in the scope where a macro is used.
`ifndef GROUPED_BITMAP_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define GROUPED_BITMAP_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GBBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GBBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/gbba_pkg.sv @@
// Constants, codes and control/status types for the block allocator.
// No dependencies; imported by the controller, datapath and top level.
`timescale 1ns / 1ps

package gbba_pkg;

  localparam int BLOCKS_PER_GROUP = 1024;
  localparam int MAX_GROUPS       = 16;
  localparam int MAP_WORD_BITS    = 64;

  localparam int WORDS_PER_GROUP  = BLOCKS_PER_GROUP / MAP_WORD_BITS;
  localparam int MAP_WORDS        = MAX_GROUPS * WORDS_PER_GROUP;

  localparam int GROUP_W    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int WIDX_W     = $clog2(WORDS_PER_GROUP);
  localparam int BIT_W      = $clog2(MAP_WORD_BITS);
  localparam int ADDR_W     = GROUP_W + WIDX_W;
  localparam int BLOCK_W    = 14;
  localparam int COUNT_W    = 11;
  localparam int TOTAL_W    = 15;
  localparam int GIU_W      = 5;
  localparam int STATUS_W   = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd2;

  typedef struct packed {
    logic                load;        // capture request, set up search
    logic                mod_step;    // reduce start group by group count
    logic                next_group;  // advance to next group, word 0
    logic                next_word;   // advance to next map word
    logic                rd;          // read the current map word
    logic                alloc_take;  // set lowest clear bit, count down
    logic                free_take;   // clear requested bit, count up
    logic                post;        // load the response register
    logic [STATUS_W-1:0] post_status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_free;
    logic free_bad;
    logic start_ge_n;
    logic group_empty;
    logic visits_done;
    logic words_done;
    logic word_full;
    logic already_free;
    logic rsp_ready;
  } dpath_stat_t;

endpackage

@@ design/grouped_bitmap_block_allocator_unit.sv @@
// Top level of the next-fit grouped bitmap block allocator.
// Depends on gbba_pkg, gbba_ctrl and gbba_dpath.
`timescale 1ns / 1ps

// Allocates and frees single blocks over 16 groups of 1024 blocks, one
// transaction at a time. A free is tested, then reads and checks its map
// word and loads the response register; a free of block zero or of a block
// beyond the groups in use goes to the response right after the test. An
// allocate reduces the start group by the group count while it lies beyond
// the groups in use (groups_in_use shrank), skips empty groups and reads
// 64-bit map words one at a time through the single read port of the map
// memory, stopping at the first word with a clear bit. Out of space is
// reported after all n groups are skipped. A stalled response register
// holds the post state. req_stall is high while a transaction is in
// progress; a finished response waits in the output register, and a new
// request is taken meanwhile. The user must write groups_in_use only
// while no transaction is pending; the block does not enforce this. After
// reset every block but block 0 is free and no clearing pass is needed.
module grouped_bitmap_block_allocator_unit
  import gbba_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [GIU_W-1:0]    cfg_data,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic                command,
  input  logic [BLOCK_W-1:0]  block_number,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [STATUS_W-1:0] status,
  output logic [BLOCK_W-1:0]  allocated_block,
  output logic [TOTAL_W-1:0]  total_free
);

  ctrl_cmd_t   cmd;
  dpath_stat_t stat;

  gbba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  gbba_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .command         (command),
    .block_number    (block_number),
    .cmd             (cmd),
    .stat            (stat),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .status          (status),
    .allocated_block (allocated_block),
    .total_free      (total_free)
  );

endmodule

@@ design/gbba_dpath.sv @@
// Datapath: used-bit map memory, group and total free counts, search
// pointers and the response register. Depends on gbba_pkg and the macros.
`timescale 1ns / 1ps
`include "grouped_bitmap_block_allocator_unit_macros.svh"

module gbba_dpath
  import gbba_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [GIU_W-1:0]    cfg_data,
  input  logic                command,
  input  logic [BLOCK_W-1:0]  block_number,
  input  ctrl_cmd_t           cmd,
  output dpath_stat_t         stat,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [STATUS_W-1:0] status,
  output logic [BLOCK_W-1:0]  allocated_block,
  output logic [TOTAL_W-1:0]  total_free
);

  logic [GIU_W-1:0]         groups_in_use;
  logic [GIU_W-1:0]         n_eff;

  logic                     req_cmd;
  logic [BLOCK_W-1:0]       req_blk;
  logic [GROUP_W-1:0]       cur_group;
  logic [GROUP_W-1:0]       start_group;
  logic [WIDX_W-1:0]        word_idx;
  logic [GIU_W-1:0]         visits;
  logic [BLOCK_W-1:0]       grant;

  logic [COUNT_W-1:0]       grp_count [MAX_GROUPS];
  logic [TOTAL_W-1:0]       free_sum;

  logic [MAP_WORD_BITS-1:0] map_mem [MAP_WORDS];
  logic [MAP_WORDS-1:0]     map_valid;
  logic [MAP_WORD_BITS-1:0] mem_rdata;
  logic                     rd_valid;
  logic                     rd_zero;
  logic [ADDR_W-1:0]        rd_addr;
  logic [ADDR_W-1:0]        addr_sel;

  logic [MAP_WORD_BITS-1:0] word;
  logic [MAP_WORD_BITS-1:0] free_vec;
  logic [BIT_W-1:0]         zero_idx;
  logic [BIT_W-1:0]         req_bit;
  logic [GROUP_W-1:0]       req_group;
  logic [MAP_WORD_BITS-1:0] wr_word;
  logic [GIU_W-1:0]         cur_plus1;

  // Register value 0 acts as one group, anything above the maximum as all.
  always_comb begin
    if (groups_in_use == '0) begin
      n_eff = GIU_W'(1);
    end else if (groups_in_use > GIU_W'(MAX_GROUPS)) begin
      n_eff = GIU_W'(MAX_GROUPS);
    end else begin
      n_eff = groups_in_use;
    end
  end

  assign req_bit   = req_blk[BIT_W-1:0];
  assign req_group = req_blk[BLOCK_W-1 -: GROUP_W];
  assign addr_sel  = (req_cmd == CMD_FREE) ? req_blk[BLOCK_W-1:BIT_W] : {cur_group, word_idx};
  assign cur_plus1 = {1'b0, cur_group} + GIU_W'(1);

  // Never-written words read as their reset value.
  assign word     = rd_valid ? mem_rdata
                             : (rd_zero ? MAP_WORD_BITS'(1) : '0);
  assign free_vec = ~word;

  always_comb begin
    zero_idx = '0;
    for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        zero_idx = BIT_W'(i);
      end
    end
  end

  assign wr_word = (req_cmd == CMD_FREE)
                 ? (word & ~(MAP_WORD_BITS'(1) << req_bit))
                 : (word | (MAP_WORD_BITS'(1) << zero_idx));

  always_comb begin
    stat.is_free      = (req_cmd == CMD_FREE);
    stat.free_bad     = (req_blk == '0) || ({1'b0, req_group} >= n_eff);
    stat.start_ge_n   = ({1'b0, cur_group} >= n_eff);
    stat.group_empty  = (grp_count[cur_group] == '0);
    stat.visits_done  = ((visits + GIU_W'(1)) == n_eff);
    stat.words_done   = (word_idx == WIDX_W'(WORDS_PER_GROUP - 1));
    stat.word_full    = (&word);
    stat.already_free = !word[req_bit];
    stat.rsp_ready    = !rsp_valid || !rsp_stall;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      groups_in_use <= GIU_W'(MAX_GROUPS);
    end else if (cfg_write) begin
      groups_in_use <= cfg_data;
    end
  end

  // Request capture and search pointers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_cmd   <= command;
      req_blk   <= block_number;
      cur_group <= start_group;
      word_idx  <= '0;
      visits    <= '0;
      grant     <= '0;
    end else begin
      if (cmd.mod_step) begin
        cur_group <= GROUP_W'({1'b0, cur_group} - n_eff);
      end
      if (cmd.next_group) begin
        cur_group <= (cur_plus1 == n_eff) ? '0 : cur_plus1[GROUP_W-1:0];
        word_idx  <= '0;
        visits    <= visits + GIU_W'(1);
      end
      if (cmd.next_word) begin
        word_idx <= word_idx + WIDX_W'(1);
      end
      if (cmd.alloc_take) begin
        grant <= {cur_group, word_idx, zero_idx};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_group <= '0;
      free_sum    <= TOTAL_W'(MAX_GROUPS * BLOCKS_PER_GROUP - 1);
      for (int g = 0; g < MAX_GROUPS; g++) begin
        grp_count[g] <= (g == 0) ? COUNT_W'(BLOCKS_PER_GROUP - 1)
                                 : COUNT_W'(BLOCKS_PER_GROUP);
      end
    end else if (cmd.alloc_take) begin
      start_group          <= cur_group;
      grp_count[cur_group] <= grp_count[cur_group] - COUNT_W'(1);
      if (free_sum != '0) begin
        free_sum <= free_sum - TOTAL_W'(1);
      end
    end else if (cmd.free_take) begin
      grp_count[req_group] <= grp_count[req_group] + COUNT_W'(1);
      free_sum             <= free_sum + TOTAL_W'(1);
    end
  end

  // Map memory: one read port with registered data, one write port.
  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      mem_rdata <= map_mem[addr_sel];
      rd_addr   <= addr_sel;
      rd_zero   <= (addr_sel == '0);
    end
    if (cmd.alloc_take || cmd.free_take) begin
      map_mem[rd_addr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      map_valid <= '0;
      rd_valid  <= 1'b0;
    end else begin
      if (cmd.rd) begin
        rd_valid <= map_valid[addr_sel];
      end
      if (cmd.alloc_take || cmd.free_take) begin
        map_valid[rd_addr] <= 1'b1;
      end
    end
  end

  // Response register: holds a finished transaction until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.post) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      status          <= cmd.post_status;
      allocated_block <= grant;
      total_free      <= free_sum;
    end
  end

  `GBBA_ASSERT_NOW(a_take_has_space, cmd.alloc_take, !stat.word_full && !stat.group_empty, "alloc take on a full word or empty group")
  `GBBA_ASSERT_NOW(a_free_bit_set, cmd.free_take, !stat.already_free && !stat.free_bad, "free take of a clear bit or bad block")
  `GBBA_ASSERT_NEXT(a_sum_down, cmd.alloc_take && (free_sum != '0), free_sum == $past(free_sum) - TOTAL_W'(1), "total free count did not drop after allocation")

endmodule

@@ design/gbba_ctrl.sv @@
// Controller: sequences request capture, group search, map word reads and
// the response hand-off. Depends on gbba_pkg and the macros.
`timescale 1ns / 1ps
`include "grouped_bitmap_block_allocator_unit_macros.svh"

module gbba_ctrl
  import gbba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  dpath_stat_t stat,
  output ctrl_cmd_t   cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TEST = 3'd1;
  localparam logic [2:0] S_WRAP = 3'd2;
  localparam logic [2:0] S_GRP  = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;
  localparam logic [2:0] S_POST = 3'd6;

  logic [2:0]          state;
  logic [2:0]          state_next;
  logic [STATUS_W-1:0] res_status;
  logic [STATUS_W-1:0] res_status_next;

  assign req_stall = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    res_status_next = res_status;
    cmd             = '0;
    cmd.post_status = res_status;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        if (!stat.is_free) begin
          state_next = S_WRAP;
        end else if (stat.free_bad) begin
          res_status_next = ST_IGNORED;
          state_next      = S_POST;
        end else begin
          state_next = S_RD;
        end
      end
      S_WRAP: begin
        // Bring the start group inside the groups in use.
        if (stat.start_ge_n) begin
          cmd.mod_step = 1'b1;
        end else begin
          state_next = S_GRP;
        end
      end
      S_GRP: begin
        if (!stat.group_empty) begin
          state_next = S_RD;
        end else if (stat.visits_done) begin
          res_status_next = ST_NO_SPACE;
          state_next      = S_POST;
        end else begin
          cmd.next_group = 1'b1;
        end
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (stat.is_free) begin
          if (stat.already_free) begin
            res_status_next = ST_IGNORED;
          end else begin
            cmd.free_take   = 1'b1;
            res_status_next = ST_DONE;
          end
          state_next = S_POST;
        end else if (!stat.word_full) begin
          cmd.alloc_take  = 1'b1;
          res_status_next = ST_DONE;
          state_next      = S_POST;
        end else if (!stat.words_done) begin
          cmd.next_word = 1'b1;
          state_next    = S_RD;
        end else if (stat.visits_done) begin
          res_status_next = ST_NO_SPACE;
          state_next      = S_POST;
        end else begin
          cmd.next_group = 1'b1;
          state_next     = S_GRP;
        end
      end
      S_POST: begin
        // Hold until the response register is free.
        if (stat.rsp_ready) begin
          cmd.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_status <= ST_DONE;
    end else begin
      state      <= state_next;
      res_status <= res_status_next;
    end
  end

  `GBBA_ASSERT_NOW(a_post_ready, cmd.post, stat.rsp_ready, "response posted while register is held")
  `GBBA_ASSERT_NEXT(a_load_tests, cmd.load, state == S_TEST, "capture not followed by the request test")
  `GBBA_ASSERT_NEXT(a_take_posts, cmd.alloc_take || cmd.free_take, (state == S_POST) && (res_status == ST_DONE), "map update without a done response")

endmodule
